@@ design/qvr_pkg.sv @@
// qvr_pkg: widths, register indexes and shared beat types of the quadratic velocity ramp
// used by qvr_step, qvr_scale and quadratic_velocity_ramp; no dependencies
package qvr_pkg;

  localparam int V_W        = 24;
  localparam int RATE_W     = 23;
  localparam int TS_W       = 18;
  localparam int FRAC_W     = 16;
  localparam int SQ_W       = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_DIVISOR_SHIFT_DEF = 3;

  localparam logic [V_W-1:0] ONE_Q16 = V_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANS_ACCEL = 2'd0,
    REG_TRANS_DECEL = 2'd1,
    REG_ROT_ACCEL   = 2'd2,
    REG_ROT_DECEL   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0] trans_accel;
    logic [RATE_W-1:0] trans_decel;
    logic [RATE_W-1:0] rot_accel;
    logic [RATE_W-1:0] rot_decel;
  } cfg_regs_t;

  // limited velocity and its time factor, between limiter and scaler
  typedef struct packed {
    logic [V_W-1:0]  lim;
    logic [TS_W-1:0] ts;
  } lim_beat_t;

endpackage

@@ design/qvr_step.sv @@
// qvr_step: four-stage limiter, quadratic step from |v|, clamp to the requested velocity
// depends on qvr_pkg
module qvr_step import qvr_pkg::*; #(
  parameter int STEP_DIVISOR_SHIFT = STEP_DIVISOR_SHIFT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_regs_t       cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_mode,
  input  logic [V_W-1:0]  in_cur,
  input  logic [V_W-1:0]  in_tgt,
  input  logic [TS_W-1:0] in_ts,
  output logic            out_valid,
  input  logic            out_ready,
  output lim_beat_t       out_beat
);

  localparam int ProdW  = SQ_W + RATE_W;
  localparam int ExtraW = ProdW - FRAC_W - STEP_DIVISOR_SHIFT;
  localparam int StepW  = ExtraW + 1;

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef struct packed {
    dir_t              dir;
    logic              zero;
    logic [RATE_W-1:0] rate;
    logic [V_W-1:0]    cur;
    logic [V_W-1:0]    tgt;
    logic [TS_W-1:0]   ts;
    logic [V_W-1:0]    diff;
  } carry_t;

  logic [3:0]        v_r;
  logic [3:0]        en;
  carry_t            a_car_r, b_car_r, c_car_r;
  carry_t            a_car_nxt;
  logic [V_W-1:0]    a_mag1_r, a_mag1_nxt;
  logic [SQ_W-1:0]   b_sq_r;
  logic [ExtraW-1:0] c_extra_r;
  lim_beat_t         d_beat_r, d_beat_nxt;

  logic [2*V_W-1:0]  sq_full;
  logic [ProdW-1:0]  ex_full;
  logic [V_W-1:0]    mag;
  logic              cur_neg, away;
  logic [RATE_W-1:0] acc, dec;
  logic [StepW-1:0]  step;
  logic              over;

  assign en[3]     = !v_r[3] || out_ready;
  assign en[2]     = !v_r[2] || en[3];
  assign en[1]     = !v_r[1] || en[2];
  assign en[0]     = !v_r[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v_r[3];
  assign out_beat  = d_beat_r;

  // entry: direction, distance to target, rate choice, |v|+1
  always_comb begin
    cur_neg = in_cur[V_W-1];
    mag     = cur_neg ? (~in_cur + V_W'(1)) : in_cur;
    acc     = in_mode ? cfg.rot_accel : cfg.trans_accel;
    dec     = in_mode ? cfg.rot_decel : cfg.trans_decel;
    a_car_nxt.cur  = in_cur;
    a_car_nxt.tgt  = in_tgt;
    a_car_nxt.ts   = in_ts;
    a_car_nxt.zero = (in_cur == '0);
    if ($signed(in_tgt) > $signed(in_cur)) begin
      a_car_nxt.dir  = DIR_UP;
      a_car_nxt.diff = in_tgt - in_cur;
    end else if ($signed(in_tgt) < $signed(in_cur)) begin
      a_car_nxt.dir  = DIR_DOWN;
      a_car_nxt.diff = in_cur - in_tgt;
    end else begin
      a_car_nxt.dir  = DIR_HOLD;
      a_car_nxt.diff = '0;
    end
    away = ((a_car_nxt.dir == DIR_UP) && !cur_neg) || ((a_car_nxt.dir == DIR_DOWN) && cur_neg);
    a_car_nxt.rate = (away || a_car_nxt.zero) ? acc : dec;
    a_mag1_nxt     = mag + ONE_Q16;
  end

  assign sq_full = (2*V_W)'(a_mag1_r) * (2*V_W)'(a_mag1_r);
  assign ex_full = ProdW'(b_sq_r) * ProdW'(b_car_r.rate);

  // clamp: never pass the target
  always_comb begin
    step = c_car_r.zero ? StepW'(c_car_r.rate) : StepW'(c_car_r.rate) + StepW'(c_extra_r);
    over = step > StepW'(c_car_r.diff);
    d_beat_nxt.ts = c_car_r.ts;
    case (c_car_r.dir)
      DIR_UP:   d_beat_nxt.lim = over ? c_car_r.tgt : c_car_r.cur + step[V_W-1:0];
      DIR_DOWN: d_beat_nxt.lim = over ? c_car_r.tgt : c_car_r.cur - step[V_W-1:0];
      default:  d_beat_nxt.lim = c_car_r.tgt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_car_r  <= a_car_nxt;
      a_mag1_r <= a_mag1_nxt;
    end
    if (en[1]) begin
      b_car_r <= a_car_r;
      b_sq_r  <= sq_full[SQ_W+FRAC_W-1:FRAC_W];
    end
    if (en[2]) begin
      c_car_r   <= b_car_r;
      c_extra_r <= ex_full[ProdW-1:FRAC_W+STEP_DIVISOR_SHIFT];
    end
    if (en[3]) begin
      d_beat_r <= d_beat_nxt;
    end
  end

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("limiter refuses a beat with a bubble in the pipe");

  a_drain_frees_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("limiter blocked although the last stage is draining");

  a_stall_keeps_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !out_ready) |=> (v_r[3] && $stable(d_beat_r)))
    else $error("stalled limiter beat lost or changed");

  a_stage_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !en[3]) |=> v_r[2])
    else $error("limiter stage dropped a beat while stalled");
`endif

endmodule

@@ design/qvr_scale.sv @@
// qvr_scale: two-stage time factor multiply, floor shift and 24-bit saturation
// depends on qvr_pkg
module qvr_scale import qvr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lim_beat_t      in_beat,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [V_W-1:0] out_speed
);

  localparam int ProdW = V_W + TS_W + 1;
  localparam int ShW   = ProdW - FRAC_W;

  localparam logic signed [ShW-1:0] SAT_MAX = ShW'((64'sd1 <<< (V_W - 1)) - 64'sd1);
  localparam logic signed [ShW-1:0] SAT_MIN = ShW'(-(64'sd1 <<< (V_W - 1)));

  logic                    e_v_r, f_v_r;
  logic                    en_e, en_f;
  logic signed [ProdW-1:0] e_prod_r, e_prod_nxt;
  logic [V_W-1:0]          f_speed_r, f_speed_nxt;
  logic signed [ShW-1:0]   shifted;

  assign en_f      = !f_v_r || out_ready;
  assign en_e      = !e_v_r || en_f;
  assign in_ready  = en_e;
  assign out_valid = f_v_r;
  assign out_speed = f_speed_r;

  assign e_prod_nxt = ProdW'($signed(in_beat.lim)) * ProdW'($signed({1'b0, in_beat.ts}));

  // dropping the low bits of a two's complement value floors it
  always_comb begin
    shifted = e_prod_r[ProdW-1:FRAC_W];
    if (shifted > SAT_MAX) begin
      f_speed_nxt = SAT_MAX[V_W-1:0];
    end else if (shifted < SAT_MIN) begin
      f_speed_nxt = SAT_MIN[V_W-1:0];
    end else begin
      f_speed_nxt = shifted[V_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      if (en_e) e_v_r <= in_valid;
      if (en_f) f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) e_prod_r  <= e_prod_nxt;
    if (en_f) f_speed_r <= f_speed_nxt;
  end

endmodule

@@ design/quadratic_velocity_ramp.sv @@
// quadratic_velocity_ramp: top level, configuration registers, limiter and scaler
// depends on qvr_pkg, qvr_step, qvr_scale
//
// Use: one command beat on in_ (mode, current and target speed, time scale) gives one
// beat on out_ (drive speed). Both channels are valid/ready; a beat moves when both are
// high. Rates are written through cfg_we / cfg_index / cfg_wdata; the user writes them only
// while no beat is in flight; the block itself does not enforce this. Pipeline: six register
// stages (rate select, square, rate product, clamp, time product, saturate).
// Throughput: one beat per cycle while out_ready is high; every stage holds a valid bit and the pipe refills
// bubbles, so in_ready stays high while any stage is empty.
// Stall: when out_ready is low the output beat holds; earlier stages keep filling
// until the pipe is full, then in_ready drops. Nothing is lost or repeated.
// Reset (rst_n low, synchronous): all stages empty, all four rates zero.
// The multipliers (24x24 square, 31x23 rate product, 24x19 time product) each sit
// alone between registers and set the clock figure.
module quadratic_velocity_ramp import qvr_pkg::*; #(
  parameter int STEP_DIVISOR_SHIFT = STEP_DIVISOR_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [V_W-1:0]       in_current_speed,
  input  logic [V_W-1:0]       in_target_speed,
  input  logic [TS_W-1:0]      in_time_scale,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [V_W-1:0]       out_drive_speed
);

  cfg_regs_t cfg_r;
  lim_beat_t lim_beat;
  logic      lim_valid, lim_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TRANS_ACCEL: cfg_r.trans_accel <= cfg_wdata;
        REG_TRANS_DECEL: cfg_r.trans_decel <= cfg_wdata;
        REG_ROT_ACCEL:   cfg_r.rot_accel   <= cfg_wdata;
        REG_ROT_DECEL:   cfg_r.rot_decel   <= cfg_wdata;
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  qvr_step #(
    .STEP_DIVISOR_SHIFT(STEP_DIVISOR_SHIFT)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_cur    (in_current_speed),
    .in_tgt    (in_target_speed),
    .in_ts     (in_time_scale),
    .out_valid (lim_valid),
    .out_ready (lim_ready),
    .out_beat  (lim_beat)
  );

  qvr_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lim_valid),
    .in_ready  (lim_ready),
    .in_beat   (lim_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_speed (out_drive_speed)
  );

endmodule
